[sv/abiog_pkg.sv]
// ----------------------------------------------------------------------------
// abiog_pkg
// Shared types, codes and tables of the arcade board io glue unit.
// ----------------------------------------------------------------------------
package abiog_pkg;

	localparam int PAL_BYTES  = 2048;
	localparam int PAL_ROWS   = PAL_BYTES / 2;
	localparam int PAL_ROW_W  = $clog2(PAL_ROWS);
	localparam int PAL_DATA_W = 16;
	localparam int OFS_W      = 19;
	localparam int BANK_W     = 4;
	localparam int APB_AW     = 3;

	localparam logic [15:0] PAL_MASK = 16'hf800;
	localparam logic [15:0] PAL_BASE = 16'h8000;

	typedef enum logic [2:0] {
		ACT_MEM_WR  = 3'd0,
		ACT_PORT_WR = 3'd1,
		ACT_PORT_RD = 3'd2,
		ACT_SND_WR  = 3'd3,
		ACT_SND_RD  = 3'd4
	} action_t;

	localparam logic [7:0] PORT_DISPLAY  = 8'h07;
	localparam logic [7:0] PORT_COIN     = 8'h10;
	localparam logic [7:0] PORT_P1       = 8'h11;
	localparam logic [7:0] PORT_P2       = 8'h12;
	localparam logic [7:0] PORT_ROM_BANK = 8'h12;
	localparam logic [7:0] PORT_LATCH    = 8'h13;
	localparam logic [7:0] PORT_DIP_A    = 8'h13;
	localparam logic [7:0] PORT_DIP_B    = 8'h14;
	localparam logic [7:0] PORT_VRAM     = 8'h17;

	localparam logic [15:0] SND_SAMPLE = 16'h9000;
	localparam logic [15:0] SND_CHIP   = 16'h9800;
	localparam logic [15:0] SND_LATCH  = 16'ha000;

	localparam logic [BANK_W-1:0] BANK_MAX = 4'd9;

	localparam logic REG_DIP_A = 1'b0;
	localparam logic REG_DIP_B = 1'b1;

	typedef struct packed {
		logic                  en;
		logic [PAL_ROW_W-1:0]  row;
		logic [PAL_DATA_W-1:0] data;
	} pal_wr_t;

	function automatic logic [OFS_W-1:0] bank_offset(input logic [BANK_W-1:0] bank);
		logic [OFS_W-1:0] ofs;
		case (bank)
			4'd0:    ofs = 19'h30000;
			4'd1:    ofs = 19'h1c000;
			4'd2:    ofs = 19'h24000;
			4'd3:    ofs = 19'h5c000;
			4'd4:    ofs = 19'h50000;
			4'd5:    ofs = 19'h44000;
			4'd6:    ofs = 19'h20000;
			4'd7:    ofs = 19'h54000;
			4'd8:    ofs = 19'h58000;
			default: ofs = 19'h08000;
		endcase
		return ofs;
	endfunction

	function automatic logic [7:0] dup4(input logic [3:0] n);
		return {n, n};
	endfunction

endpackage

[sv/abiog_ram.sv]
// ----------------------------------------------------------------------------
// abiog_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abiog_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/abiog_pal.sv]
// ----------------------------------------------------------------------------
// abiog_pal
// Palette store: row memory of byte pairs, clearing sweep after reset and
// forwarding of the last write when its row matches the registered read row.
// ----------------------------------------------------------------------------
module abiog_pal import abiog_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [PAL_ROW_W-1:0]  rd_row,
	input  pal_wr_t               wr,
	output logic [PAL_DATA_W-1:0] row_data,
	output logic                  busy
);

	logic                  clr_act_q;
	logic [PAL_ROW_W-1:0]  clr_row_q;
	logic                  fwd_v_q;
	logic [PAL_ROW_W-1:0]  fwd_row_q;
	logic [PAL_DATA_W-1:0] fwd_data_q;
	logic [PAL_ROW_W-1:0]  rd_row_q;
	logic                  ram_we;
	logic [PAL_ROW_W-1:0]  ram_waddr;
	logic [PAL_DATA_W-1:0] ram_wdata;
	logic [PAL_DATA_W-1:0] ram_rdata;

	// sweep zeros through every row after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_act_q) begin
			clr_row_q <= clr_row_q + PAL_ROW_W'(1);
			if (clr_row_q == PAL_ROW_W'(PAL_ROWS - 1)) begin
				clr_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr.en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_row_q  <= wr.row;
			fwd_data_q <= wr.data;
		end
		if (rd_en) begin
			rd_row_q <= rd_row;
		end
	end

	assign ram_we    = clr_act_q | wr.en;
	assign ram_waddr = clr_act_q ? clr_row_q : wr.row;
	assign ram_wdata = clr_act_q ? '0 : wr.data;

	abiog_ram #(
		.WIDTH (PAL_DATA_W),
		.DEPTH (PAL_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	assign row_data = (fwd_v_q && fwd_row_q == rd_row_q) ? fwd_data_q : ram_rdata;
	assign busy     = clr_act_q;

endmodule

[sv/arcade_board_io_glue_unit.sv]
// ----------------------------------------------------------------------------
// arcade_board_io_glue_unit
// Bus glue of a two-CPU arcade board: palette store, bank and display
// registers, sound latch and interrupt, input and DIP port reads.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// req       req_valid / req_stall      action address data coin_start_bits
//                                      player_one_bits player_two_bits chip_status
// rsp       rsp_valid / rsp_stall      read_data rom_bank_offset vram_bank
//                                      display_on sound_irq sample_bank palette_*
//                                      red green blue command_strobe
// cfg       apb psel/penable/pwrite    dip_a at 0x0, dip_b at 0x4
//
// one item per cycle unless stalled; read stage, then output register
// the palette row is read at accept and written back when the item advances
// after reset a sweep clears all 1024 palette rows; req_stall is high meanwhile
// rsp_stall holds the output register; one more item waits in the read stage
// ----------------------------------------------------------------------------
module arcade_board_io_glue_unit import abiog_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        action,
	input  logic [15:0]       address,
	input  logic [7:0]        data,
	input  logic [7:0]        coin_start_bits,
	input  logic [7:0]        player_one_bits,
	input  logic [7:0]        player_two_bits,
	input  logic [7:0]        chip_status,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [7:0]        read_data,
	output logic [OFS_W-1:0]  rom_bank_offset,
	output logic              vram_bank,
	output logic              display_on,
	output logic              sound_irq,
	output logic [1:0]        sample_bank,
	output logic              palette_valid,
	output logic [9:0]        palette_index,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              command_strobe
);

	logic [7:0] dip_a_q;
	logic [7:0] dip_b_q;
	logic       cfg_wr;

	logic              s1_v_q;
	logic [2:0]        action_s1;
	logic [15:0]       address_s1;
	logic [7:0]        data_s1;
	logic [7:0]        coin_s1;
	logic [7:0]        p1_s1;
	logic [7:0]        p2_s1;
	logic [7:0]        status_s1;

	logic [BANK_W-1:0] rom_bank_q;
	logic              vram_q;
	logic              display_q;
	logic [7:0]        latch_q;
	logic              irq_q;
	logic [1:0]        sample_q;

	logic              accept;
	logic              adv;
	logic              pal_busy;
	logic [15:0]       row_data;
	pal_wr_t           pal_wr;

	logic [7:0]        port;
	logic [7:0]        old_byte;
	logic [15:0]       new_row;
	logic              pal_hit;
	logic              pal_chg;
	logic [7:0]        rd_n;
	logic              strobe_n;
	logic [BANK_W-1:0] rom_bank_n;
	logic              vram_n;
	logic              display_n;
	logic [7:0]        latch_n;
	logic              irq_n;
	logic [1:0]        sample_n;

	logic [7:0]        read_data_q;
	logic              rsp_v_q;
	logic              pv_q;
	logic [9:0]        pidx_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic              strobe_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_a_q <= 8'hff;
			dip_b_q <= 8'hff;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DIP_A) begin
				dip_a_q <= pwdata[7:0];
			end else begin
				dip_b_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = {24'd0, (paddr[2] == REG_DIP_A) ? dip_a_q : dip_b_q};

	// handshake
	assign adv       = s1_v_q & (~rsp_v_q | ~rsp_stall);
	assign req_stall = pal_busy | (s1_v_q & ~adv);
	assign accept    = req_valid & ~req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			address_s1 <= address;
			data_s1    <= data;
			coin_s1    <= coin_start_bits;
			p1_s1      <= player_one_bits;
			p2_s1      <= player_two_bits;
			status_s1  <= chip_status;
		end
	end

	abiog_pal u_pal (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_row   (address[PAL_ROW_W:1]),
		.wr       (pal_wr),
		.row_data (row_data),
		.busy     (pal_busy)
	);

	// palette read-modify-write
	assign pal_hit  = (address_s1 & PAL_MASK) == PAL_BASE;
	assign old_byte = address_s1[0] ? row_data[15:8] : row_data[7:0];
	assign new_row  = address_s1[0] ? {data_s1, row_data[7:0]} : {row_data[15:8], data_s1};
	assign pal_chg  = (action_t'(action_s1) == ACT_MEM_WR) && pal_hit && (old_byte != data_s1);

	assign pal_wr.en   = adv & pal_chg;
	assign pal_wr.row  = address_s1[PAL_ROW_W:1];
	assign pal_wr.data = new_row;

	// register decode
	assign port = address_s1[7:0];

	always_comb begin
		rd_n       = 8'd0;
		strobe_n   = 1'b0;
		rom_bank_n = rom_bank_q;
		vram_n     = vram_q;
		display_n  = display_q;
		latch_n    = latch_q;
		irq_n      = irq_q;
		sample_n   = sample_q;
		case (action_t'(action_s1))
			ACT_PORT_WR: begin
				if (port == PORT_DISPLAY) begin
					display_n = ~data_s1[0];
				end else if (port == PORT_ROM_BANK) begin
					rom_bank_n = (data_s1 > 8'(BANK_MAX - BANK_W'(1))) ? BANK_MAX :
						data_s1[BANK_W-1:0];
				end else if (port == PORT_LATCH) begin
					latch_n = data_s1;
					irq_n   = 1'b1;
				end else if (port == PORT_VRAM) begin
					vram_n = data_s1[0];
				end
			end
			ACT_PORT_RD: begin
				if (port == PORT_COIN) begin
					rd_n = coin_s1;
				end else if (port == PORT_P1) begin
					rd_n = p1_s1;
				end else if (port == PORT_P2) begin
					rd_n = p2_s1;
				end else if (port == PORT_DIP_A) begin
					rd_n = dip_a_q;
				end else if (port == PORT_DIP_B) begin
					rd_n = dip_b_q;
				end
			end
			ACT_SND_WR: begin
				if (address_s1 == SND_SAMPLE) begin
					sample_n = data_s1[1:0];
				end else if (address_s1 == SND_CHIP) begin
					strobe_n = 1'b1;
				end
			end
			ACT_SND_RD: begin
				if (address_s1 == SND_CHIP) begin
					rd_n = status_s1;
				end else if (address_s1 == SND_LATCH) begin
					rd_n  = latch_q;
					irq_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= '0;
			vram_q     <= 1'b0;
			display_q  <= 1'b0;
			latch_q    <= 8'd0;
			irq_q      <= 1'b0;
			sample_q   <= 2'd1;
			rsp_v_q    <= 1'b0;
		end else begin
			if (adv) begin
				rom_bank_q <= rom_bank_n;
				vram_q     <= vram_n;
				display_q  <= display_n;
				latch_q    <= latch_n;
				irq_q      <= irq_n;
				sample_q   <= sample_n;
				rsp_v_q    <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= rd_n;
			strobe_q    <= strobe_n;
			pv_q        <= pal_chg;
			pidx_q      <= pal_chg ? address_s1[PAL_ROW_W:1] : '0;
			red_q       <= pal_chg ? dup4(new_row[11:8]) : 8'd0;
			green_q     <= pal_chg ? dup4(new_row[7:4]) : 8'd0;
			blue_q      <= pal_chg ? dup4(new_row[3:0]) : 8'd0;
		end
	end

	assign rsp_valid       = rsp_v_q;
	assign read_data       = read_data_q;
	assign rom_bank_offset = bank_offset(rom_bank_q);
	assign vram_bank       = vram_q;
	assign display_on      = display_q;
	assign sound_irq       = irq_q;
	assign sample_bank     = sample_q;
	assign palette_valid   = pv_q;
	assign palette_index   = pidx_q;
	assign red             = red_q;
	assign green           = green_q;
	assign blue            = blue_q;
	assign command_strobe  = strobe_q;

`ifndef SYNTHESIS
	a_no_item_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pal_busy |-> !s1_v_q)
		else $error("item in read stage during palette clear");

	a_held_item_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && !adv) |-> !pal_wr.en)
		else $error("palette written by a held item");

	a_irq_rise_by_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_q) |-> $past(adv))
		else $error("sound irq raised without an item");
`endif

endmodule
